[rtl/core/serial_memory_bridge_engine_defines.svh]
// Assertion macros shared by the RTL.
`ifndef SERIAL_MEMORY_BRIDGE_ENGINE_DEFINES_SVH
`define SERIAL_MEMORY_BRIDGE_ENGINE_DEFINES_SVH

`define SMB_ASSERT_IMPL(label, clk_s, rst_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error(msg);

`define SMB_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/smbe_pkg.sv]
package smbe_pkg;

    localparam int ADDR_WIDTH_DEF = 16;
    localparam int MAX_RES = 5;
    localparam int RES_CNT_W = 3;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [1:0] OP_HOST = 2'd0;
    localparam logic [1:0] OP_MEMRD = 2'd1;
    localparam logic [1:0] OP_TIMEOUT = 2'd2;
    localparam logic [1:0] OP_POLL = 2'd3;

    localparam logic [1:0] MEM_NONE = 2'd0;
    localparam logic [1:0] MEM_READ = 2'd1;
    localparam logic [1:0] MEM_WRITE = 2'd2;

    localparam logic [2:0] REG_CHIP_KNOWN = 3'd0;
    localparam logic [2:0] REG_CHIP_SIZE = 3'd1;
    localparam logic [2:0] REG_VERSION = 3'd2;
    localparam logic [2:0] REG_SLOW = 3'd3;
    localparam logic [2:0] REG_CMD_VER = 3'd4;
    localparam logic [2:0] REG_CMD_RD = 3'd5;
    localparam logic [2:0] REG_CMD_WR = 3'd6;

    localparam logic [7:0] PROBE_PATTERN = 8'hA5;
    localparam logic [7:0] BYTE_ONES = 8'hFF;
    localparam logic [7:0] BYTE_ZERO = 8'h00;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] data_byte;
    } item_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
        end
        return c;
    endfunction

endpackage

[rtl/core/smbe_front.sv]
module smbe_front
    import smbe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  op,
    input  logic [7:0]  data_byte,
    output logic        q_valid,
    input  logic        q_ready,
    output item_t       q_item
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    item_t              mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W:0]     count_reg;
    logic               push;
    logic               pop;

    assign in_ready = (count_reg != (PTR_W+1)'(QUEUE_DEPTH));
    assign q_valid  = (count_reg != '0);
    assign q_item   = mem_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= '{op: op, data_byte: data_byte};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
        end
    end

endmodule

[rtl/core/smbe_back.sv]
module smbe_back
    import smbe_pkg::*;
#(
    parameter int ADDR_WIDTH = ADDR_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [2:0]            cfg_index,
    input  logic [16:0]           cfg_data,
    input  logic                  q_valid,
    output logic                  q_ready,
    input  item_t                 q_item,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  tx_valid,
    output logic [7:0]            tx_byte,
    output logic [1:0]            mem_op,
    output logic [ADDR_WIDTH-1:0] mem_addr,
    output logic [7:0]            mem_wdata,
    output logic                  busy_res,
    output logic                  last
);

    typedef enum logic [3:0] {
        PH_IDLE, PH_ACK, PH_HDR, PH_READ, PH_READ_WAIT, PH_WRITE,
        PH_VERIFY, PH_VERIFY_WAIT, PH_PROBE_READ, PH_PROBE_CHECK
    } phase_t;

    typedef struct packed {
        logic                  txv;
        logic [7:0]            tx;
        logic [1:0]            mop;
        logic [ADDR_WIDTH-1:0] addr;
        logic [7:0]            wd;
    } res_t;

    localparam logic [31:0] ADDR_MAX = 32'((64'd1 << ADDR_WIDTH) - 64'd1);

    logic        known_reg;
    logic [16:0] chip_reg;
    logic [15:0] ver_reg;
    logic        slow_reg;
    logic [7:0]  cver_reg;
    logic [7:0]  crd_reg;
    logic [7:0]  cwr_reg;

    phase_t                phase_reg, phase_next;
    logic [7:0]            pend_reg, pend_next;
    logic [63:0]           hdr_reg, hdr_next;
    logic [3:0]            hcnt_reg, hcnt_next;
    logic [ADDR_WIDTH-1:0] cur_reg, cur_next;
    logic [31:0]           left_reg, left_next;
    logic [ADDR_WIDTH-1:0] start_reg, start_next;
    logic [31:0]           size_reg, size_next;
    logic [31:0]           crc_reg, crc_next;
    logic                  pulled_reg, pulled_next;
    logic [31:0]           vleft_reg, vleft_next;
    logic [7:0]            saved_reg, saved_next;

    res_t                  buf_reg [MAX_RES];
    res_t                  buf_next [MAX_RES];
    logic [RES_CNT_W-1:0]  n_reg, n_next;
    logic [RES_CNT_W-1:0]  idx_reg;
    logic                  busy_reg, busy_next;

    logic [1:0]  op_i;
    logic [7:0]  d;
    logic [31:0] a32, sz, addr32, crc_fin, crc_upd;
    logic        take;
    logic        draining;

    assign op_i     = q_item.op;
    assign d        = q_item.data_byte;
    assign draining = (n_reg != '0);
    assign q_ready  = !draining || (out_ready && last);
    assign take     = q_valid && q_ready;
    assign crc_fin  = ~crc_reg;
    assign crc_upd  = crc_byte(crc_reg, d);

    assign out_valid = draining;
    assign tx_valid  = buf_reg[idx_reg].txv;
    assign tx_byte   = buf_reg[idx_reg].tx;
    assign mem_op    = buf_reg[idx_reg].mop;
    assign mem_addr  = buf_reg[idx_reg].addr;
    assign mem_wdata = buf_reg[idx_reg].wd;
    assign busy_res  = busy_reg;
    assign last      = (idx_reg == n_reg - 1'b1);

    always_comb
    begin
        a32 = hdr_next[63:32];
        sz  = hdr_next[31:0];
        if (a32 > ADDR_MAX)
        begin
            sz     = '0;
            addr32 = '0;
        end
        else
        begin
            addr32 = a32;
        end
        if (known_reg)
        begin
            if (chip_reg == '0)
            begin
                sz = '0;
            end
            else if (addr32 > {15'd0, chip_reg} - 32'd1)
            begin
                sz = '0;
            end
            else if ({15'd0, chip_reg} - addr32 < sz)
            begin
                sz = {15'd0, chip_reg} - addr32;
            end
        end
    end

    always_comb
    begin
        int k;
        phase_next  = phase_reg;
        pend_next   = pend_reg;
        hdr_next    = hdr_reg;
        hcnt_next   = hcnt_reg;
        cur_next    = cur_reg;
        left_next   = left_reg;
        start_next  = start_reg;
        size_next   = size_reg;
        crc_next    = crc_reg;
        pulled_next = pulled_reg;
        vleft_next  = vleft_reg;
        saved_next  = saved_reg;
        k = 0;
        for (int i = 0; i < MAX_RES; i++)
        begin
            buf_next[i] = '0;
        end
        case (phase_reg)
            PH_IDLE:
            begin
                if (op_i == OP_HOST)
                begin
                    buf_next[0] = '{1'b1, d, MEM_NONE, '0, '0};
                    k = 1;
                    pend_next  = d;
                    phase_next = PH_ACK;
                end
            end
            PH_ACK:
            begin
                if (op_i == OP_TIMEOUT)
                begin
                    phase_next = PH_IDLE;
                end
                else if (op_i == OP_HOST)
                begin
                    phase_next = PH_IDLE;
                    if (d == BYTE_ZERO)
                    begin
                        if (pend_reg == cver_reg)
                        begin
                            buf_next[0] = '{1'b1, ver_reg[15:8], MEM_NONE, '0, '0};
                            buf_next[1] = '{1'b1, ver_reg[7:0], MEM_NONE, '0, '0};
                            k = 2;
                        end
                        else if (pend_reg == crd_reg)
                        begin
                            hdr_next   = '0;
                            hcnt_next  = '0;
                            phase_next = PH_HDR;
                        end
                        else if (pend_reg == cwr_reg)
                        begin
                            buf_next[0] = '{1'b1, {7'd0, slow_reg}, MEM_NONE, '0, '0};
                            k = 1;
                            hdr_next   = '0;
                            hcnt_next  = '0;
                            phase_next = PH_HDR;
                        end
                    end
                end
            end
            PH_HDR:
            begin
                if (op_i == OP_TIMEOUT)
                begin
                    phase_next = PH_IDLE;
                end
                else if (op_i == OP_HOST)
                begin
                    hdr_next  = {hdr_reg[55:0], d};
                    hcnt_next = hcnt_reg + 4'd1;
                    if (hcnt_reg + 4'd1 >= 4'd8)
                    begin
                        hcnt_next  = '0;
                        buf_next[0] = '{1'b1, sz[31:24], MEM_NONE, '0, '0};
                        buf_next[1] = '{1'b1, sz[23:16], MEM_NONE, '0, '0};
                        buf_next[2] = '{1'b1, sz[15:8], MEM_NONE, '0, '0};
                        buf_next[3] = '{1'b1, sz[7:0], MEM_NONE, '0, '0};
                        k = 4;
                        start_next = addr32[ADDR_WIDTH-1:0];
                        cur_next   = addr32[ADDR_WIDTH-1:0];
                        size_next  = sz;
                        left_next  = sz;
                        crc_next   = '1;
                        phase_next = (pend_reg == crd_reg) ? PH_READ : PH_WRITE;
                    end
                end
            end
            PH_READ:
            begin
                if (op_i == OP_POLL)
                begin
                    if (left_reg != '0)
                    begin
                        buf_next[0] = '{1'b0, 8'd0, MEM_READ, cur_reg, 8'd0};
                        k = 1;
                        phase_next = PH_READ_WAIT;
                    end
                    else
                    begin
                        buf_next[0] = '{1'b1, crc_fin[31:24], MEM_NONE, '0, '0};
                        buf_next[1] = '{1'b1, crc_fin[23:16], MEM_NONE, '0, '0};
                        buf_next[2] = '{1'b1, crc_fin[15:8], MEM_NONE, '0, '0};
                        buf_next[3] = '{1'b1, crc_fin[7:0], MEM_NONE, '0, '0};
                        k = 4;
                        phase_next = PH_IDLE;
                    end
                end
            end
            PH_READ_WAIT:
            begin
                if (op_i == OP_MEMRD)
                begin
                    crc_next    = crc_upd;
                    buf_next[0] = '{1'b1, d, MEM_NONE, '0, '0};
                    k = 1;
                    cur_next   = cur_reg + 1'b1;
                    left_next  = left_reg - 32'd1;
                    phase_next = PH_READ;
                end
            end
            PH_WRITE:
            begin
                if (left_reg != '0)
                begin
                    if (op_i == OP_TIMEOUT)
                    begin
                        phase_next = PH_IDLE;
                    end
                    else if (op_i == OP_HOST)
                    begin
                        buf_next[0] = '{1'b0, 8'd0, MEM_WRITE, cur_reg, d};
                        k = 1;
                        cur_next  = cur_reg + 1'b1;
                        left_next = left_reg - 32'd1;
                    end
                end
                else if (op_i == OP_POLL)
                begin
                    cur_next    = start_reg;
                    vleft_next  = size_reg;
                    pulled_next = 1'b1;
                    phase_next  = PH_VERIFY;
                end
            end
            PH_VERIFY:
            begin
                if (op_i == OP_POLL)
                begin
                    if (vleft_reg != '0)
                    begin
                        buf_next[0] = '{1'b0, 8'd0, MEM_READ, cur_reg, 8'd0};
                        k = 1;
                        phase_next = PH_VERIFY_WAIT;
                    end
                    else
                    begin
                        buf_next[0] = '{1'b1, crc_fin[31:24], MEM_NONE, '0, '0};
                        buf_next[1] = '{1'b1, crc_fin[23:16], MEM_NONE, '0, '0};
                        buf_next[2] = '{1'b1, crc_fin[15:8], MEM_NONE, '0, '0};
                        buf_next[3] = '{1'b1, crc_fin[7:0], MEM_NONE, '0, '0};
                        k = 5;
                        if (pulled_reg)
                        begin
                            buf_next[4] = '{1'b0, 8'd0, MEM_READ, start_reg, 8'd0};
                            phase_next  = PH_PROBE_READ;
                        end
                        else
                        begin
                            buf_next[4] = '{1'b1, 8'd0, MEM_NONE, '0, '0};
                            phase_next  = PH_IDLE;
                        end
                    end
                end
            end
            PH_VERIFY_WAIT:
            begin
                if (op_i == OP_MEMRD)
                begin
                    crc_next = crc_upd;
                    if (d != BYTE_ONES && d != BYTE_ZERO)
                    begin
                        pulled_next = 1'b0;
                    end
                    cur_next   = cur_reg + 1'b1;
                    vleft_next = vleft_reg - 32'd1;
                    phase_next = PH_VERIFY;
                end
            end
            PH_PROBE_READ:
            begin
                if (op_i == OP_MEMRD)
                begin
                    saved_next  = d;
                    buf_next[0] = '{1'b0, 8'd0, MEM_WRITE, start_reg, PROBE_PATTERN};
                    buf_next[1] = '{1'b0, 8'd0, MEM_READ, start_reg, 8'd0};
                    k = 2;
                    phase_next = PH_PROBE_CHECK;
                end
            end
            PH_PROBE_CHECK:
            begin
                if (op_i == OP_MEMRD)
                begin
                    buf_next[0] = '{1'b0, 8'd0, MEM_WRITE, start_reg, saved_reg};
                    buf_next[1] = '{1'b1, {7'd0, (d != PROBE_PATTERN)}, MEM_NONE, '0, '0};
                    k = 2;
                    phase_next = PH_IDLE;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
        n_next    = RES_CNT_W'(k);
        busy_next = (phase_next >= PH_READ);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            known_reg <= 1'b0;
            chip_reg  <= 17'h10000;
            ver_reg   <= '0;
            slow_reg  <= 1'b0;
            cver_reg  <= 8'd0;
            crd_reg   <= 8'd2;
            cwr_reg   <= 8'd3;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CHIP_KNOWN: known_reg <= cfg_data[0];
                REG_CHIP_SIZE:  chip_reg  <= cfg_data;
                REG_VERSION:    ver_reg   <= cfg_data[15:0];
                REG_SLOW:       slow_reg  <= cfg_data[0];
                REG_CMD_VER:    cver_reg  <= cfg_data[7:0];
                REG_CMD_RD:     crd_reg   <= cfg_data[7:0];
                REG_CMD_WR:     cwr_reg   <= cfg_data[7:0];
                default:        known_reg <= known_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            pend_reg   <= '0;
            hdr_reg    <= '0;
            hcnt_reg   <= '0;
            cur_reg    <= '0;
            left_reg   <= '0;
            start_reg  <= '0;
            size_reg   <= '0;
            crc_reg    <= '1;
            pulled_reg <= 1'b1;
            vleft_reg  <= '0;
            saved_reg  <= '0;
            n_reg      <= '0;
            idx_reg    <= '0;
            busy_reg   <= 1'b0;
        end
        else if (take)
        begin
            phase_reg  <= phase_next;
            pend_reg   <= pend_next;
            hdr_reg    <= hdr_next;
            hcnt_reg   <= hcnt_next;
            cur_reg    <= cur_next;
            left_reg   <= left_next;
            start_reg  <= start_next;
            size_reg   <= size_next;
            crc_reg    <= crc_next;
            pulled_reg <= pulled_next;
            vleft_reg  <= vleft_next;
            saved_reg  <= saved_next;
            n_reg      <= n_next;
            idx_reg    <= '0;
            busy_reg   <= busy_next;
        end
        else if (draining && out_ready)
        begin
            if (last)
            begin
                n_reg   <= '0;
                idx_reg <= '0;
            end
            else
            begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            for (int i = 0; i < MAX_RES; i++)
            begin
                buf_reg[i] <= buf_next[i];
            end
        end
    end

endmodule

[rtl/core/serial_memory_bridge_engine.sv]
// Serial memory bridge engine: runs host commands against a byte memory.
// Input beats (in_valid/in_ready) carry op and data_byte: host bytes, memory
// read data, host timeouts and poll advances. Each input beat yields zero to
// five output beats (out_valid/out_ready) with host bytes or memory requests;
// last marks the final beat caused by one input, busy_res is high while a read
// or write operation is still running.
// Input beats pass through a two-entry queue into the command unit. The
// command unit takes one queued beat per cycle when it has no results left
// or its last result is being accepted; results are registered and appear in
// the cycle after the beat is taken. An accepted input beat passes through
// the queue and the result buffer registers before its first result appears.
// When the receiver stalls, results hold and the queue fills; in_ready
// drops once both queue entries are taken.
// Reset clears the queue, the command phase (waiting for a command) and the
// configuration registers to their default values.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user must write it only while idle (not enforced).
module serial_memory_bridge_engine
    import smbe_pkg::*;
#(
    parameter int ADDR_WIDTH = ADDR_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [2:0]            cfg_index,
    input  logic [16:0]           cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            op,
    input  logic [7:0]            data_byte,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  tx_valid,
    output logic [7:0]            tx_byte,
    output logic [1:0]            mem_op,
    output logic [ADDR_WIDTH-1:0] mem_addr,
    output logic [7:0]            mem_wdata,
    output logic                  busy_res,
    output logic                  last
);

`include "serial_memory_bridge_engine_defines.svh"

    logic  q_valid;
    logic  q_ready;
    item_t q_item;

    smbe_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .data_byte (data_byte),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_item    (q_item)
    );

    smbe_back #(.ADDR_WIDTH(ADDR_WIDTH)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_item    (q_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .tx_valid  (tx_valid),
        .tx_byte   (tx_byte),
        .mem_op    (mem_op),
        .mem_addr  (mem_addr),
        .mem_wdata (mem_wdata),
        .busy_res  (busy_res),
        .last      (last)
    );

    `SMB_ASSERT_IMPL(a_no_take_while_draining, clk, rst_n, out_valid && !(out_ready && last), !q_ready, "took beat while draining")
    `SMB_ASSERT_IMPL(a_tx_excl_mem, clk, rst_n, out_valid && tx_valid, mem_op == MEM_NONE, "tx with mem request")
    `SMB_ASSERT_NEXT(a_stall_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(tx_byte) && $stable(mem_op), "result changed under stall")

endmodule
